// ----- design/framed_packet_receiver_assert.svh -----
// assertion macros for the framed packet receiver
// used by fpr_ctrl and fpr_datapath; no other dependencies
`ifndef FRAMED_PACKET_RECEIVER_ASSERT_SVH
`define FRAMED_PACKET_RECEIVER_ASSERT_SVH

`ifndef SYNTH

// concurrent check on a clock, off while reset is high
`define FPR_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fpr assertion failed");

// concurrent check on a clock, also active during reset
`define FPR_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("fpr assertion failed");

`else

`define FPR_ASSERT(name, clk, rst, prop)
`define FPR_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// ----- design/fpr_pkg.sv -----
// shared types and constants of the framed packet receiver
// no dependencies
package fpr_pkg;

   // register indexes of the csr port
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_CODE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_CODE   = 1'b1;

   // register reset values
   localparam logic [7:0] START_CODE_RESET = 8'h02;
   localparam logic [7:0] END_CODE_RESET   = 8'h03;

   // result status codes
   localparam logic [1:0] STS_NONE      = 2'd0;
   localparam logic [1:0] STS_ACCEPT    = 2'd1;
   localparam logic [1:0] STS_REJECT    = 2'd2;
   localparam logic [1:0] STS_TOO_LONG  = 2'd3;

   // controller states
   typedef enum logic [2:0] {
      ST_HUNT,
      ST_LEN,
      ST_DATA,
      ST_CHK,
      ST_END,
      ST_RD,
      ST_OUT
   } state_type;

   // kind of result loaded into the output register
   typedef enum logic [1:0] {
      OUT_PAYLOAD,
      OUT_EMPTY,
      OUT_REJECT,
      OUT_TOO_LONG
   } out_kind_type;

   // controller to datapath
   typedef struct packed {
      logic         clear_frame;
      logic         load_length;
      logic         store_byte;
      logic         load_checksum;
      logic         rd_clear;
      logic         rd_advance;
      logic         out_load;
      out_kind_type out_kind;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_start;
      logic len_too_long;
      logic len_zero;
      logic count_done;
      logic frame_good;
      logic len_empty;
      logic rd_last;
      logic out_free;
   } status_type;

endpackage

// ----- design/fpr_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module fpr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/fpr_datapath.sv -----
// datapath: code registers, frame counters, checksums, payload store, result register
// depends on fpr_pkg, fpr_ram and framed_packet_receiver_assert.svh
`include "framed_packet_receiver_assert.svh"

module fpr_datapath #(
   parameter int unsigned MAX_PAYLOAD = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [fpr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [7:0]                          csr_data,
   input  logic [7:0]                          req_rx_byte,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_byte_valid,
   output logic [7:0]                          rsp_payload_byte,
   output logic                                rsp_last,
   input  fpr_pkg::cmd_type                    cmd,
   output fpr_pkg::status_type                 status
);

   localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
   localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic [7:0]    start_code_ff, start_code_in;
   logic [7:0]    end_code_ff, end_code_in;
   logic [CW-1:0] frame_length_ff, frame_length_in;
   logic [CW-1:0] byte_count_ff, byte_count_in;
   logic [7:0]    run_chk_ff, run_chk_in;
   logic [7:0]    rcv_chk_ff, rcv_chk_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic          rsp_byte_valid_ff, rsp_byte_valid_in;
   logic [7:0]    rsp_payload_byte_ff, rsp_payload_byte_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [7:0]    rd_data;
   logic [CW:0]   count_next;
   logic [CW:0]   rd_next;

   // csr writes
   always_comb begin
      start_code_in = start_code_ff;
      end_code_in   = end_code_ff;
      if (csr_write) begin
         case (csr_index)
            fpr_pkg::CSR_START_CODE: start_code_in = csr_data;
            fpr_pkg::CSR_END_CODE:   end_code_in   = csr_data;
            default: ;
         endcase
      end
   end

   // frame bookkeeping
   always_comb begin
      frame_length_in = frame_length_ff;
      byte_count_in   = byte_count_ff;
      run_chk_in      = run_chk_ff;
      rcv_chk_in      = rcv_chk_ff;
      if (cmd.clear_frame) begin
         frame_length_in = '0;
         byte_count_in   = '0;
         run_chk_in      = '0;
      end
      if (cmd.load_length) begin
         frame_length_in = req_rx_byte[CW-1:0];
      end
      if (cmd.store_byte) begin
         byte_count_in = byte_count_ff + CW'(1);
         run_chk_in    = run_chk_ff ^ req_rx_byte;
      end
      if (cmd.load_checksum) begin
         rcv_chk_in = req_rx_byte;
      end
   end

   // read index for the payload run
   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (cmd.rd_clear) begin
         rd_idx_in = '0;
      end else if (cmd.rd_advance) begin
         rd_idx_in = rd_idx_ff + CW'(1);
      end
   end

   // result register
   always_comb begin
      rsp_valid_in        = rsp_valid_ff & rsp_stall;
      rsp_status_in       = rsp_status_ff;
      rsp_byte_valid_in   = rsp_byte_valid_ff;
      rsp_payload_byte_in = rsp_payload_byte_ff;
      rsp_last_in         = rsp_last_ff;
      if (cmd.out_load) begin
         rsp_valid_in        = 1'b1;
         rsp_byte_valid_in   = 1'b0;
         rsp_payload_byte_in = 8'h00;
         rsp_last_in         = 1'b1;
         case (cmd.out_kind)
            fpr_pkg::OUT_PAYLOAD: begin
               rsp_status_in       = fpr_pkg::STS_ACCEPT;
               rsp_byte_valid_in   = 1'b1;
               rsp_payload_byte_in = rd_data;
               rsp_last_in         = status.rd_last;
            end
            fpr_pkg::OUT_EMPTY:    rsp_status_in = fpr_pkg::STS_ACCEPT;
            fpr_pkg::OUT_REJECT:   rsp_status_in = fpr_pkg::STS_REJECT;
            fpr_pkg::OUT_TOO_LONG: rsp_status_in = fpr_pkg::STS_TOO_LONG;
            default:               rsp_status_in = fpr_pkg::STS_NONE;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff   <= fpr_pkg::START_CODE_RESET;
         end_code_ff     <= fpr_pkg::END_CODE_RESET;
         frame_length_ff <= '0;
         byte_count_ff   <= '0;
         run_chk_ff      <= '0;
         rcv_chk_ff      <= '0;
         rd_idx_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         start_code_ff   <= start_code_in;
         end_code_ff     <= end_code_in;
         frame_length_ff <= frame_length_in;
         byte_count_ff   <= byte_count_in;
         run_chk_ff      <= run_chk_in;
         rcv_chk_ff      <= rcv_chk_in;
         rd_idx_ff       <= rd_idx_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload registers
   always_ff @(posedge clock) begin
      rsp_status_ff       <= rsp_status_in;
      rsp_byte_valid_ff   <= rsp_byte_valid_in;
      rsp_payload_byte_ff <= rsp_payload_byte_in;
      rsp_last_ff         <= rsp_last_in;
   end

   // payload store
   fpr_ram #(
      .WIDTH (8),
      .DEPTH (MAX_PAYLOAD)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.store_byte),
      .wr_addr (byte_count_ff[AW-1:0]),
      .wr_data (req_rx_byte),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // status back to the controller
   assign count_next = {1'b0, byte_count_ff} + (CW+1)'(1);
   assign rd_next    = {1'b0, rd_idx_ff} + (CW+1)'(1);

   always_comb begin
      status.is_start     = (req_rx_byte == start_code_ff);
      status.len_too_long = (req_rx_byte > 8'(MAX_PAYLOAD));
      status.len_zero     = (req_rx_byte == 8'h00);
      status.count_done   = (count_next >= {1'b0, frame_length_ff});
      status.frame_good   = (req_rx_byte == end_code_ff) && (run_chk_ff == rcv_chk_ff);
      status.len_empty    = (frame_length_ff == '0);
      status.rd_last      = (rd_next == {1'b0, frame_length_ff});
      status.out_free     = ~rsp_valid_ff | ~rsp_stall;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_byte_valid   = rsp_byte_valid_ff;
   assign rsp_payload_byte = rsp_payload_byte_ff;
   assign rsp_last         = rsp_last_ff;

   // checks
   `FPR_ASSERT(a_store_in_range, clock, reset, cmd.store_byte |-> (byte_count_ff < CW'(MAX_PAYLOAD)))
   `FPR_ASSERT(a_load_shows_valid, clock, reset, cmd.out_load |=> rsp_valid_ff)
   `FPR_ASSERT(a_status_only_last, clock, reset, (rsp_valid_ff && !rsp_byte_valid_ff) |-> rsp_last_ff)

endmodule

// ----- design/fpr_ctrl.sv -----
// controller state machine of the framed packet receiver
// depends on fpr_pkg and framed_packet_receiver_assert.svh
`include "framed_packet_receiver_assert.svh"

module fpr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  fpr_pkg::status_type status,
   output fpr_pkg::cmd_type    cmd
);

   fpr_pkg::state_type state_ff, state_in;
   logic               in_state;
   logic               fire;

   // bytes are taken only while hunting or in the frame states and with the result slot free
   always_comb begin
      case (state_ff)
         fpr_pkg::ST_HUNT, fpr_pkg::ST_LEN, fpr_pkg::ST_DATA,
         fpr_pkg::ST_CHK, fpr_pkg::ST_END: in_state = 1'b1;
         default:                          in_state = 1'b0;
      endcase
   end

   assign req_stall = ~(in_state & status.out_free);
   assign fire      = req_valid & ~req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fpr_pkg::ST_HUNT: begin
            if (fire && status.is_start) state_in = fpr_pkg::ST_LEN;
         end
         fpr_pkg::ST_LEN: begin
            if (fire) begin
               if (status.len_too_long)  state_in = fpr_pkg::ST_HUNT;
               else if (status.len_zero) state_in = fpr_pkg::ST_CHK;
               else                      state_in = fpr_pkg::ST_DATA;
            end
         end
         fpr_pkg::ST_DATA: begin
            if (fire && status.count_done) state_in = fpr_pkg::ST_CHK;
         end
         fpr_pkg::ST_CHK: begin
            if (fire) state_in = fpr_pkg::ST_END;
         end
         fpr_pkg::ST_END: begin
            if (fire) begin
               if (status.frame_good && !status.len_empty) state_in = fpr_pkg::ST_RD;
               else                                        state_in = fpr_pkg::ST_HUNT;
            end
         end
         fpr_pkg::ST_RD: begin
            state_in = fpr_pkg::ST_OUT;
         end
         fpr_pkg::ST_OUT: begin
            if (status.out_free) begin
               if (status.rd_last) state_in = fpr_pkg::ST_HUNT;
               else                state_in = fpr_pkg::ST_RD;
            end
         end
         default: state_in = fpr_pkg::ST_HUNT;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      cmd.out_kind = fpr_pkg::OUT_PAYLOAD;
      case (state_ff)
         fpr_pkg::ST_HUNT: begin
            cmd.clear_frame = fire & status.is_start;
         end
         fpr_pkg::ST_LEN: begin
            if (fire) begin
               if (status.len_too_long) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = fpr_pkg::OUT_TOO_LONG;
               end else begin
                  cmd.load_length = 1'b1;
               end
            end
         end
         fpr_pkg::ST_DATA: begin
            cmd.store_byte = fire;
         end
         fpr_pkg::ST_CHK: begin
            cmd.load_checksum = fire;
         end
         fpr_pkg::ST_END: begin
            if (fire) begin
               if (!status.frame_good) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = fpr_pkg::OUT_REJECT;
               end else if (status.len_empty) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = fpr_pkg::OUT_EMPTY;
               end else begin
                  cmd.rd_clear = 1'b1;
               end
            end
         end
         fpr_pkg::ST_OUT: begin
            cmd.out_load   = status.out_free;
            cmd.rd_advance = status.out_free;
         end
         default: ;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fpr_pkg::ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   `FPR_ASSERT(a_rd_then_out, clock, reset, (state_ff == fpr_pkg::ST_RD) |=> (state_ff == fpr_pkg::ST_OUT))
   `FPR_ASSERT(a_load_needs_slot, clock, reset, cmd.out_load |-> status.out_free)
   `FPR_ASSERT_ALWAYS(a_no_take_in_run, clock, ((state_ff == fpr_pkg::ST_RD) || (state_ff == fpr_pkg::ST_OUT)) |-> req_stall)

endmodule

// ----- design/framed_packet_receiver.sv -----
// top level of the framed packet receiver: controller plus datapath
// depends on fpr_pkg, fpr_ctrl, fpr_datapath
//
//   channel  ports                                  direction  transfer when
//   req      req_valid req_stall req_rx_byte         in         req_valid & !req_stall
//   rsp      rsp_valid rsp_stall rsp_status ...      out        rsp_valid & !rsp_stall
//   csr      csr_write csr_index csr_data            in         csr_write
//
// one received byte per cycle while hunting or inside a frame
// an accepted frame gives its payload one byte at a time, each read in ST_RD and shown from
// ST_OUT, as the payload store has a registered read; no bytes are taken during that run
// any byte waits while the result register is full and held by rsp_stall
// reset is synchronous and active high; it restores the default start and end codes
module framed_packet_receiver #(
   parameter int unsigned MAX_PAYLOAD = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [fpr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                      csr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_byte_valid,
   output logic [7:0]                      rsp_payload_byte,
   output logic                            rsp_last
);

   fpr_pkg::cmd_type    cmd;
   fpr_pkg::status_type status;

   // sequencing
   fpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and checks of the frame
   fpr_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_rx_byte      (req_rx_byte),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ----- verif/framed_packet_receiver_tb.sv -----
// self-checking testbench of framed_packet_receiver: byte stream in, frame results out
// depends on fpr_pkg and framed_packet_receiver; a scoreboard class predicts every result
module framed_packet_receiver_tb;

   localparam int unsigned PAYLOAD_MAX   = 16;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned LONG_HOLD     = 80;
   localparam int unsigned MAX_REPORTS   = 10;
   localparam int unsigned HOLD_AT_ITEM  = 35;

   typedef struct packed {
      logic [1:0] status;
      logic       byte_valid;
      logic [7:0] payload_byte;
      logic       last;
   } frame_result_type;

   // predicts the results of the receiver from every byte transfer and checks them
   class frame_scoreboard;
      logic [7:0]          start_code;
      logic [7:0]          end_code;
      fpr_pkg::state_type  phase;
      logic [7:0]          payload_mem [PAYLOAD_MAX];
      int unsigned         frame_len;
      int unsigned         byte_cnt;
      logic [7:0]          calc_sum;
      logic [7:0]          recv_sum;
      frame_result_type    due_results [$];
      int unsigned         mismatches;
      int unsigned         checked;

      function new();
         start_code = fpr_pkg::START_CODE_RESET;
         end_code   = fpr_pkg::END_CODE_RESET;
         phase      = fpr_pkg::ST_HUNT;
         frame_len  = 0;
         byte_cnt   = 0;
         calc_sum   = 8'h00;
         recv_sum   = 8'h00;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void set_code(logic [fpr_pkg::CSR_INDEX_W-1:0] idx, logic [7:0] value);
         if (idx == fpr_pkg::CSR_START_CODE) begin
            start_code = value;
         end else if (idx == fpr_pkg::CSR_END_CODE) begin
            end_code = value;
         end
      endfunction

      function void push_result(logic [1:0] st, logic bv, logic [7:0] data, logic lst);
         frame_result_type r;
         r.status       = st;
         r.byte_valid   = bv;
         r.payload_byte = data;
         r.last         = lst;
         due_results.push_back(r);
      endfunction

      // advance the frame parser by one received byte
      function void take_byte(logic [7:0] b);
         case (phase)
            fpr_pkg::ST_LEN: begin
               if (b > PAYLOAD_MAX) begin
                  phase = fpr_pkg::ST_HUNT;
                  push_result(fpr_pkg::STS_TOO_LONG, 1'b0, 8'h00, 1'b1);
               end else begin
                  frame_len = b;
                  phase = (b == 0) ? fpr_pkg::ST_CHK : fpr_pkg::ST_DATA;
               end
            end
            fpr_pkg::ST_DATA: begin
               if (byte_cnt < PAYLOAD_MAX) payload_mem[byte_cnt] = b;
               calc_sum = calc_sum ^ b;
               byte_cnt++;
               if (byte_cnt >= frame_len) phase = fpr_pkg::ST_CHK;
            end
            fpr_pkg::ST_CHK: begin
               recv_sum = b;
               phase = fpr_pkg::ST_END;
            end
            fpr_pkg::ST_END: begin
               phase = fpr_pkg::ST_HUNT;
               if (b == end_code && calc_sum == recv_sum) begin
                  if (frame_len == 0) begin
                     push_result(fpr_pkg::STS_ACCEPT, 1'b0, 8'h00, 1'b1);
                  end else begin
                     for (int unsigned i = 0; i < frame_len && i < PAYLOAD_MAX; i++)
                        push_result(fpr_pkg::STS_ACCEPT, 1'b1, payload_mem[i],
                                    i + 1 == frame_len);
                  end
               end else begin
                  push_result(fpr_pkg::STS_REJECT, 1'b0, 8'h00, 1'b1);
               end
            end
            default: begin
               // hunting, unused codes behave the same
               phase = fpr_pkg::ST_HUNT;
               if (b == start_code) begin
                  phase     = fpr_pkg::ST_LEN;
                  frame_len = 0;
                  byte_cnt  = 0;
                  calc_sum  = 8'h00;
               end
            end
         endcase
      endfunction

      function void note_mismatch(string what);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("mismatch: %s", what);
      endfunction

      // compare one result transfer with the oldest expected result
      function void check_result(frame_result_type got);
         frame_result_type want;
         checked++;
         if (due_results.size() == 0) begin
            note_mismatch($sformatf("unexpected result status=%0d bv=%0d byte=%02h last=%0d",
                                    got.status, got.byte_valid, got.payload_byte, got.last));
         end else begin
            want = due_results.pop_front();
            if (got.status !== want.status || got.byte_valid !== want.byte_valid ||
                got.payload_byte !== want.payload_byte || got.last !== want.last)
               note_mismatch({
                  $sformatf("result %0d expected st=%0d bv=%0d byte=%02h last=%0d",
                            checked, want.status, want.byte_valid, want.payload_byte,
                            want.last),
                  $sformatf(" got st=%0d bv=%0d byte=%02h last=%0d",
                            got.status, got.byte_valid, got.payload_byte, got.last)});
         end
      endfunction

      function int unsigned pending();
         return due_results.size();
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_write = 1'b0;
   logic [fpr_pkg::CSR_INDEX_W-1:0] csr_index = fpr_pkg::CSR_START_CODE;
   logic [7:0]                      csr_data = 8'h00;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [7:0]                      req_rx_byte = 8'h00;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [1:0]                      rsp_status;
   logic                            rsp_byte_valid;
   logic [7:0]                      rsp_payload_byte;
   logic                            rsp_last;

   frame_scoreboard sb = new();
   logic [7:0]      cur_start = fpr_pkg::START_CODE_RESET;
   logic [7:0]      cur_end = fpr_pkg::END_CODE_RESET;
   bit              steady = 1'b0;
   bit              held_long = 1'b0;
   int unsigned     items_sent = 0;

   framed_packet_receiver #(
      .MAX_PAYLOAD(PAYLOAD_MAX)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_last        (rsp_last)
   );

   // clock, period 4
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // offer one byte, return at the edge of its transfer with valid still high
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.take_byte(b);
      items_sent++;
   endtask

   // one frame in the current codes; lengths above the store end after the length byte
   task automatic send_frame(input int unsigned len, input bit sum_ok, input bit end_ok);
      logic [7:0] data;
      logic [7:0] sum;
      sum = 8'h00;
      send_byte(cur_start);
      send_byte(len[7:0]);
      if (len <= PAYLOAD_MAX) begin
         for (int unsigned i = 0; i < len; i++) begin
            data = 8'($urandom_range(0, 255));
            sum  = sum ^ data;
            send_byte(data);
         end
         send_byte(sum_ok ? sum : sum ^ 8'($urandom_range(1, 255)));
         send_byte(end_ok ? cur_end : cur_end ^ 8'($urandom_range(1, 255)));
      end
   endtask

   // stop offering and wait until every expected result has come and the block settles
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write both code registers on consecutive edges while the block is idle
   task automatic write_codes(input logic [7:0] start_val, input logic [7:0] end_val);
      csr_write <= 1'b1;
      csr_index <= fpr_pkg::CSR_START_CODE;
      csr_data  <= start_val;
      @(posedge clock);
      sb.set_code(fpr_pkg::CSR_START_CODE, start_val);
      csr_index <= fpr_pkg::CSR_END_CODE;
      csr_data  <= end_val;
      @(posedge clock);
      sb.set_code(fpr_pkg::CSR_END_CODE, end_val);
      csr_write <= 1'b0;
      cur_start = start_val;
      cur_end   = end_val;
   endtask

   // mostly well-formed frames with random content, some noise and broken frames
   task automatic random_frames(input int unsigned count);
      int unsigned stop_at;
      int unsigned pick;
      int unsigned len;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 10) len = $urandom_range(PAYLOAD_MAX + 1, 255);
            else if (pick < 25) len = PAYLOAD_MAX;
            else len = $urandom_range(0, PAYLOAD_MAX);
            send_frame(len, $urandom_range(0, 99) >= 15, $urandom_range(0, 99) >= 10);
         end
      end
   endtask

   // result side: random stall per transfer, one long hold to back the block up
   initial begin : rsp_side
      int unsigned hold;
      frame_result_type got;
      wait (!reset);
      forever begin
         hold = steady ? 0 : $urandom_range(0, 5);
         if (!held_long && items_sent >= HOLD_AT_ITEM) begin
            hold = LONG_HOLD;
            held_long = 1'b1;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         got.status       = rsp_status;
         got.byte_valid   = rsp_byte_valid;
         got.payload_byte = rsp_payload_byte;
         got.last         = rsp_last;
         sb.check_result(got);
      end
   end

   // stimulus
   initial begin : req_side
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: noise, empty frame, too long, single byte, bad checksum, bad end code
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(0, 1'b1, 1'b1);
      send_frame(PAYLOAD_MAX + 1, 1'b1, 1'b1);
      send_frame(255, 1'b1, 1'b1);
      send_frame(1, 1'b1, 1'b1);
      send_frame(1, 1'b0, 1'b1);
      send_frame(0, 1'b1, 1'b0);
      drain();

      // reset codes, then extreme codes, then random codes
      random_frames(25);
      drain();
      write_codes(8'h00, 8'hFF);
      steady = 1'b1;
      random_frames(10);
      steady = 1'b0;
      random_frames(10);
      drain();
      write_codes(8'hFF, 8'h00);
      random_frames(15);
      drain();
      write_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      random_frames(15);
      drain();

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("framed_packet_receiver_tb: PASS");
      end else begin
         $display("framed_packet_receiver_tb: FAIL");
      end
      $finish;
   end

   // run limit
   initial begin : watchdog
      #400000;
      $display("framed_packet_receiver_tb: FAIL");
      $finish;
   end

endmodule
